[design/serial_response_line_tracker_assert.svh]
// Assertion macros used by the serial response line tracker top level.
// Expects clk and rst_n in the scope of every use.
`ifndef SERIAL_RESPONSE_LINE_TRACKER_ASSERT_SVH
`define SERIAL_RESPONSE_LINE_TRACKER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define SRLT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SRLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/srlt_pkg.sv]
// Types, codes and the character filter of the serial response line tracker.
// No dependencies.
package srlt_pkg;

  // Fixed widths of the result fields.
  localparam int STATUS_W = 4;
  localparam int LEN_W    = 13;
  localparam int COUNT_W  = 16;
  localparam int DEPTH_W  = 8;
  localparam int CFG_IDX_W = 2;

  // Special characters.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_EOF    = 8'hFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_PATTERN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LENGTH  = 2'd2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 4'd0,
    ST_CR_SKIP   = 4'd1,
    ST_DISCARD   = 4'd2,
    ST_LINE_FULL = 4'd3,
    ST_BLANK     = 4'd4,
    ST_HELD      = 4'd5,
    ST_POSTED    = 4'd6,
    ST_ACK       = 4'd7,
    ST_EOF_HALT  = 4'd8,
    ST_JSON_HALT = 4'd9,
    ST_HALTED    = 4'd10,
    ST_REQUEST   = 4'd11
  } status_t;

  // Configuration register contents.
  typedef struct packed {
    logic        sync_mode;
    logic [63:0] ack_pattern;
    logic [3:0]  ack_length;
  } cfg_t;

  // True for the bytes that may be stored in a reply line.
  function automatic logic char_accepted(input logic [7:0] c);
    logic ok;
    ok = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
         (c inside {8'h2E, 8'h2D, 8'h5F, 8'h2F, 8'h7B, 8'h7D, 8'h28, 8'h29,
                    8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h3A, 8'h2C,
                    8'h20, 8'h09});
    return ok;
  endfunction

endpackage

[design/srlt_cfg.sv]
// Configuration registers of the serial response line tracker.
// Depends on srlt_pkg.
module srlt_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [srlt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  output srlt_pkg::cfg_t                 cfg,
  output logic                           clear_pending
);
  import srlt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write transaction into the register it targets.
  always_comb begin
    cfg_nxt = cfg_r;
    clear_pending = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC_MODE: begin
          cfg_nxt.sync_mode = cfg_data[0];
          clear_pending = (cfg_data[0] != cfg_r.sync_mode);
        end
        CFG_ACK_PATTERN: cfg_nxt.ack_pattern = cfg_data;
        CFG_ACK_LENGTH:  cfg_nxt.ack_length = cfg_data[3:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/srlt_step.sv]
// Per-item update of the tracker state: filtering, braces, line and ack logic.
// Depends on srlt_pkg.
module srlt_step #(
  parameter int LINE_LIMIT = 4096,
  parameter int JSON_LIMIT = 4096,
  localparam int LINE_W = $clog2(LINE_LIMIT + 1),
  localparam int JSON_W = $clog2(JSON_LIMIT + 1)
) (
  input  srlt_pkg::cfg_t                  cfg,
  input  logic                            mode,
  input  logic [7:0]                      rx_byte,
  input  logic [srlt_pkg::DEPTH_W-1:0]    depth_cur,
  input  logic [JSON_W-1:0]               inner_cur,
  input  logic [LINE_W-1:0]               line_cur,
  input  logic                            match_cur,
  input  logic [srlt_pkg::COUNT_W-1:0]    held_cur,
  input  logic [srlt_pkg::COUNT_W-1:0]    pend_cur,
  input  logic                            halted_cur,
  output logic [srlt_pkg::DEPTH_W-1:0]    depth_nxt,
  output logic [JSON_W-1:0]               inner_nxt,
  output logic [LINE_W-1:0]               line_nxt,
  output logic                            match_nxt,
  output logic [srlt_pkg::COUNT_W-1:0]    held_nxt,
  output logic [srlt_pkg::COUNT_W-1:0]    pend_nxt,
  output logic                            halted_nxt,
  output srlt_pkg::status_t               status,
  output logic                            inner_byte
);
  import srlt_pkg::*;

  localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(LINE_LIMIT);
  localparam logic [JSON_W-1:0] JSON_MAX = JSON_W'(JSON_LIMIT);
  localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};
  localparam logic [DEPTH_W-1:0] DEPTH_SAT = {DEPTH_W{1'b1}};

  logic [DEPTH_W-1:0] depth_up;
  logic [DEPTH_W-1:0] depth_dn;
  logic [JSON_W-1:0]  inner_base;
  logic [JSON_W-1:0]  inner_inc;
  logic               inner_hit;
  logic [7:0]         pat_byte;
  logic               byte_match;
  logic               is_ack;
  logic [COUNT_W-1:0] held_inc;

  // Brace depth and inner byte count for an accepted byte.
  assign inner_base = (rx_byte == CH_LBRACE && depth_cur == '0) ? '0 : inner_cur;
  assign depth_up   = (rx_byte == CH_LBRACE && depth_cur != DEPTH_SAT) ?
                      depth_cur + 1'b1 : depth_cur;
  assign inner_hit  = depth_up > DEPTH_W'(1);
  assign inner_inc  = inner_base + 1'b1;
  assign depth_dn   = (rx_byte == CH_RBRACE && depth_up != '0) ? depth_up - 1'b1 : depth_up;

  // Pattern byte at the current line position.
  assign pat_byte   = cfg.ack_pattern[{line_cur[2:0], 3'b000} +: 8];
  assign byte_match = (line_cur < LINE_W'(8)) && (pat_byte == rx_byte);
  assign is_ack     = match_cur && (cfg.ack_length >= 4'd1) && (cfg.ack_length <= 4'd8) &&
                      (line_cur == LINE_W'(cfg.ack_length));
  assign held_inc   = (held_cur != COUNT_SAT) ? held_cur + 1'b1 : held_cur;

  // Item dispatch in priority order.
  always_comb begin
    depth_nxt  = depth_cur;
    inner_nxt  = inner_cur;
    line_nxt   = line_cur;
    match_nxt  = match_cur;
    held_nxt   = held_cur;
    pend_nxt   = pend_cur;
    halted_nxt = halted_cur;
    status     = ST_ACCEPTED;
    inner_byte = 1'b0;
    if (mode) begin
      if (pend_cur != COUNT_SAT) begin
        pend_nxt = pend_cur + 1'b1;
      end
      status = ST_REQUEST;
    end else if (halted_cur) begin
      status = ST_HALTED;
    end else if (rx_byte == CH_EOF) begin
      line_nxt   = '0;
      match_nxt  = 1'b1;
      halted_nxt = 1'b1;
      status     = ST_EOF_HALT;
    end else if (rx_byte == CH_CR) begin
      status = ST_CR_SKIP;
    end else if (rx_byte == CH_LF) begin
      if (line_cur == '0) begin
        status = ST_BLANK;
      end else begin
        held_nxt = held_inc;
        if (is_ack && pend_cur != '0) begin
          pend_nxt = pend_cur - 1'b1;
        end
        if (!cfg.sync_mode || is_ack) begin
          held_nxt = '0;
          status   = is_ack ? ST_ACK : ST_POSTED;
        end else begin
          status = ST_HELD;
        end
        line_nxt  = '0;
        match_nxt = 1'b1;
      end
    end else if (!char_accepted(rx_byte)) begin
      status = ST_DISCARD;
    end else begin
      inner_nxt  = inner_hit ? inner_inc : inner_base;
      inner_byte = inner_hit;
      if (inner_hit && inner_inc == JSON_MAX) begin
        // Inner store is full: stop before the closing brace and the line.
        depth_nxt  = depth_up;
        halted_nxt = 1'b1;
        status     = ST_JSON_HALT;
      end else begin
        depth_nxt = depth_dn;
        if (line_cur >= LINE_MAX) begin
          status = ST_LINE_FULL;
        end else begin
          match_nxt = match_cur && byte_match;
          line_nxt  = line_cur + 1'b1;
          status    = ST_ACCEPTED;
        end
      end
    end
  end

endmodule

[design/serial_response_line_tracker.sv]
// Top level of the serial response line tracker: input and result registers,
// tracker state. Depends on srlt_pkg, srlt_cfg, srlt_step and the assert header.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_mode, in_rx_byte
//   out_     output     out_valid/out_stall  status, inner byte, depth, lengths, counts
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while in_stall is low.
// The item is decoded between the input register and the result register,
// and the state counters update in the same cycle that the result is loaded.
// in_stall rises only while both registers are full and out_stall is high.
// Synchronous active-low reset clears state, counters and configuration.
module serial_response_line_tracker #(
  parameter int LINE_LIMIT = 4096,
  parameter int JSON_LIMIT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [srlt_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_inner_json_byte,
  output logic [srlt_pkg::DEPTH_W-1:0]   out_brace_depth,
  output logic [srlt_pkg::LEN_W-1:0]     out_inner_json_length,
  output logic [srlt_pkg::LEN_W-1:0]     out_line_length,
  output logic [srlt_pkg::COUNT_W-1:0]   out_held_lines,
  output logic [srlt_pkg::COUNT_W-1:0]   out_outstanding,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srlt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);
  import srlt_pkg::*;
  `include "serial_response_line_tracker_assert.svh"

  localparam int LINE_W = $clog2(LINE_LIMIT + 1);
  localparam int JSON_W = $clog2(JSON_LIMIT + 1);

  cfg_t    cfg;
  logic    clear_pending;

  // Input register.
  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_byte_r;
  logic       advance;
  logic       in_take;

  // Tracker state.
  logic [DEPTH_W-1:0] depth_r;
  logic [JSON_W-1:0]  inner_r;
  logic [LINE_W-1:0]  line_r;
  logic               match_r;
  logic [COUNT_W-1:0] held_r;
  logic [COUNT_W-1:0] pend_r;
  logic               halted_r;

  logic [DEPTH_W-1:0] depth_nxt;
  logic [JSON_W-1:0]  inner_nxt;
  logic [LINE_W-1:0]  line_nxt;
  logic               match_nxt;
  logic [COUNT_W-1:0] held_nxt;
  logic [COUNT_W-1:0] pend_nxt;
  logic               halted_nxt;
  status_t            status_nxt;
  logic               inner_byte_nxt;

  // Result register.
  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_inner_byte_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic [LEN_W-1:0]   out_inner_len_r;
  logic [LEN_W-1:0]   out_line_len_r;
  logic [COUNT_W-1:0] out_held_r;
  logic [COUNT_W-1:0] out_pend_r;

  assign cfg_ready = 1'b1;

  srlt_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg           (cfg),
    .clear_pending (clear_pending)
  );

  srlt_step #(
    .LINE_LIMIT (LINE_LIMIT),
    .JSON_LIMIT (JSON_LIMIT)
  ) u_step (
    .cfg        (cfg),
    .mode       (s1_mode_r),
    .rx_byte    (s1_byte_r),
    .depth_cur  (depth_r),
    .inner_cur  (inner_r),
    .line_cur   (line_r),
    .match_cur  (match_r),
    .held_cur   (held_r),
    .pend_cur   (pend_r),
    .halted_cur (halted_r),
    .depth_nxt  (depth_nxt),
    .inner_nxt  (inner_nxt),
    .line_nxt   (line_nxt),
    .match_nxt  (match_nxt),
    .held_nxt   (held_nxt),
    .pend_nxt   (pend_nxt),
    .halted_nxt (halted_nxt),
    .status     (status_nxt),
    .inner_byte (inner_byte_nxt)
  );

  // The held item moves on whenever the result register is free or being taken.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Input register control and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_rx_byte;
    end
  end

  // Tracker state update; a sync mode change clears the outstanding count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      inner_r  <= '0;
      line_r   <= '0;
      match_r  <= 1'b1;
      held_r   <= '0;
      pend_r   <= '0;
      halted_r <= 1'b0;
    end else begin
      if (advance) begin
        depth_r  <= depth_nxt;
        inner_r  <= inner_nxt;
        line_r   <= line_nxt;
        match_r  <= match_nxt;
        held_r   <= held_nxt;
        halted_r <= halted_nxt;
      end
      if (clear_pending) begin
        pend_r <= '0;
      end else if (advance) begin
        pend_r <= pend_nxt;
      end
    end
  end

  // Result register control and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r     <= status_nxt;
      out_inner_byte_r <= inner_byte_nxt;
      out_depth_r      <= depth_nxt;
      out_inner_len_r  <= LEN_W'(inner_nxt);
      out_line_len_r   <= LEN_W'(line_nxt);
      out_held_r       <= held_nxt;
      out_pend_r       <= pend_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_inner_json_byte   = out_inner_byte_r;
  assign out_brace_depth       = out_depth_r;
  assign out_inner_json_length = out_inner_len_r;
  assign out_line_length       = out_line_len_r;
  assign out_held_lines        = out_held_r;
  assign out_outstanding       = out_pend_r;

  // Checks on the pipeline and state.
  `SRLT_ASSERT_IMPL(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r,
                    "input stalled without a full pipeline")
  `SRLT_ASSERT_NEXT(a_advance_loads, advance, out_valid_r,
                    "advanced item did not reach the result register")
  `SRLT_ASSERT_NEXT(a_halt_sticks, halted_r, halted_r,
                    "halt cleared without reset")
  `SRLT_ASSERT_IMPL(a_line_bound, 1'b1, line_r <= LINE_W'(LINE_LIMIT),
                    "line count beyond its limit")
  `SRLT_ASSERT_IMPL(a_request_no_inner,
                    out_valid_r && out_status_r == ST_REQUEST, !out_inner_byte_r,
                    "request result flagged as inner byte")

endmodule
